>>> hw/rtl/utu_pkg.sv
// Package for the UTF-16 to UTF-8 transcoder.
// Holds the code-unit ranges, the byte prefixes and the job type that the
// front end hands to the back end. Depends on nothing.
package utu_pkg;

    localparam int UNIT_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int MAX_BYTES  = 6;
    localparam int CNT_W      = 3;
    localparam int HELD_W     = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
    localparam logic [UNIT_W-1:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [UNIT_W-1:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
        logic                             str_end;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> hw/rtl/utu_channels.sv
// Handshake channels of the transcoder: code units in, UTF-8 bytes out.
// Depends on utu_pkg for the field widths.
interface utu_unit_if;
    import utu_pkg::*;
    logic              valid;
    logic              ready;
    logic [UNIT_W-1:0] code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink   (input valid, input code_unit, output ready);
endinterface

interface utu_byte_if;
    import utu_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              string_end;

    modport source (output valid, output out_byte, output last_of_run,
                    output string_end, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input string_end, output ready);
endinterface

>>> hw/rtl/utu_channels_top_note.sv
// Byte counter checker is not used; this file holds the transcoder top level.
// Depends on utu_pkg, utu_channels, utu_front, utu_queue and utu_back.
module utf16_to_utf8_transcoder
    import utu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    utu_unit_if.sink   unit_ch,
    utu_byte_if.source byte_ch
);

    // The block sends one UTF-8 byte per cycle while the output is ready. A code unit yields
    // no bytes for a high surrogate that is held, one to three for most units, four for a
    // surrogate pair, and up to six when a held surrogate is flushed ahead of the next unit.
    // The back end sends these through a single output byte register; a new unit is accepted
    // every cycle while the two-entry job queue has room.

    q_stat_t q_stat;
    logic    push, pop;
    job_t    push_job, pop_job;

    utu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .unit_ch  (unit_ch),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    utu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    utu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .pop_job (pop_job),
        .pop     (pop),
        .byte_ch (byte_ch)
    );

endmodule

>>> hw/rtl/utu_front.sv
// Front end: accepts code units, pairs surrogates and builds the byte job.
// Depends on utu_pkg and utu_channels.
module utu_front
    import utu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    utu_unit_if.sink     unit_ch,
    input  q_stat_t      q_stat,
    output logic         push,
    output job_t         push_job
);

    typedef struct packed {
        logic [2:0][BYTE_W-1:0] b;
        logic [1:0]             n;
    } enc_t;

    function automatic enc_t encode_bmp(input logic [UNIT_W-1:0] u);
        enc_t e;
        e = '0;
        if (u < ONE_BYTE_LIMIT) begin
            e.b[0] = u[7:0];
            e.n    = 2'd1;
        end else if (u < TWO_BYTE_LIMIT) begin
            e.b[0] = {LEAD2_TAG, u[10:6]};
            e.b[1] = {CONT_TAG, u[5:0]};
            e.n    = 2'd2;
        end else begin
            e.b[0] = {LEAD3_TAG, u[15:12]};
            e.b[1] = {CONT_TAG, u[11:6]};
            e.b[2] = {CONT_TAG, u[5:0]};
            e.n    = 2'd3;
        end
        return e;
    endfunction

    logic              held_valid_reg, held_valid_next;
    logic [HELD_W-1:0] held_bits_reg, held_bits_next;
    logic              accept;
    logic              is_high, is_low;
    logic [20:0]       supp;
    enc_t              flush_enc, tail_enc;
    logic [2:0][BYTE_W-1:0] tail_b;
    logic [1:0]        tail_n;
    job_t              job;

    assign unit_ch.ready = !q_stat.full;
    assign accept  = unit_ch.valid && unit_ch.ready;
    assign is_high = unit_ch.code_unit[15:10] == HIGH_SURR_TAG;
    assign is_low  = unit_ch.code_unit[15:10] == LOW_SURR_TAG;
    assign supp    = SUPP_BASE + {1'b0, held_bits_reg, unit_ch.code_unit[9:0]};
    assign flush_enc = encode_bmp({HIGH_SURR_TAG, held_bits_reg});
    assign tail_enc  = encode_bmp(unit_ch.code_unit);

    always_comb
    begin
        job             = '0;
        tail_b          = '0;
        tail_n          = 2'd0;
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (held_valid_reg && is_low) begin
            job.bytes[0]    = {LEAD4_TAG, supp[20:18]};
            job.bytes[1]    = {CONT_TAG, supp[17:12]};
            job.bytes[2]    = {CONT_TAG, supp[11:6]};
            job.bytes[3]    = {CONT_TAG, supp[5:0]};
            job.count       = 3'd4;
            held_valid_next = 1'b0;
            held_bits_next  = '0;
        end else begin
            held_valid_next = 1'b0;
            held_bits_next  = '0;
            if (unit_ch.code_unit == '0) begin
                tail_b[0]   = '0;
                tail_n      = 2'd1;
                job.str_end = 1'b1;
            end else if (is_high) begin
                held_valid_next = 1'b1;
                held_bits_next  = unit_ch.code_unit[HELD_W-1:0];
            end else begin
                tail_b = tail_enc.b;
                tail_n = tail_enc.n;
            end
            if (held_valid_reg) begin
                job.bytes[0] = flush_enc.b[0];
                job.bytes[1] = flush_enc.b[1];
                job.bytes[2] = flush_enc.b[2];
                for (int i = 0; i < 3; i++) begin
                    job.bytes[3+i] = tail_b[i];
                end
                job.count = 3'd3 + {1'b0, tail_n};
            end else begin
                for (int i = 0; i < 3; i++) begin
                    job.bytes[i] = tail_b[i];
                end
                job.count = {1'b0, tail_n};
            end
        end
    end

    assign push     = accept && (job.count != '0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end else if (accept) begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

>>> hw/rtl/utu_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on utu_pkg.
module utu_queue
    import utu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  job_t    push_job,
    input  logic    pop,
    output job_t    pop_job,
    output q_stat_t q_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg, fill_next;

    assign q_stat.full  = fill_reg == (PTR_W+1)'(QUEUE_DEPTH);
    assign q_stat.empty = fill_reg == '0;
    assign pop_job      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hw/rtl/utu_back.sv
// Back end: walks the current job and sends one UTF-8 byte per cycle through
// an output register while ready is high. Depends on utu_pkg and utu_channels.
module utu_back
    import utu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_stat_t    q_stat,
    input  job_t       pop_job,
    output logic       pop,
    utu_byte_if.source byte_ch
);

    logic              cur_valid_reg, cur_valid_next;
    job_t              cur_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg, out_end_reg;
    logic              out_load, at_last, finish;

    assign out_load = !out_valid_reg || byte_ch.ready;
    assign at_last  = idx_reg == (cur_reg.count - 1'b1);
    assign finish   = cur_valid_reg && out_load && at_last;
    assign pop      = !q_stat.empty && (!cur_valid_reg || finish);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (finish) begin
            cur_valid_next = 1'b0;
            idx_next       = '0;
        end else if (cur_valid_reg && out_load) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (out_load) begin
                out_valid_reg <= cur_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            cur_reg <= pop_job;
        end
        if (out_load) begin
            out_byte_reg <= cur_reg.bytes[idx_reg];
            out_last_reg <= at_last;
            out_end_reg  <= at_last && cur_reg.str_end;
        end
    end

    assign byte_ch.valid       = out_valid_reg;
    assign byte_ch.out_byte    = out_byte_reg;
    assign byte_ch.last_of_run = out_last_reg;
    assign byte_ch.string_end  = out_end_reg;

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg < cur_reg.count))
        else $error("byte index ran past the end of the job");

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (cur_reg.count != '0) && (cur_reg.count <= CNT_W'(MAX_BYTES)))
        else $error("job with an impossible byte count");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> (out_last_reg && (out_byte_reg == '0)))
        else $error("string end flag on a byte that is not the final zero");

    a_no_pop_mid_job: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_valid_reg && !finish) |-> !pop)
        else $error("queue popped while the current job still has bytes");

endmodule
